### design/v3a_pkg.sv
package v3a_pkg;

  localparam int CW = 24;
  localparam int SW = 2 * CW;
  localparam int NW = CW;
  localparam int QW = 33;
  localparam int AW = 18;
  localparam int RW = 31;
  localparam int XW = 34;
  localparam int ZW = 44;
  localparam int NORM_STEPS = CW;
  localparam int DIV_STEPS = QW - 1;
  localparam int ROOT_STEPS = RW;
  localparam int CORDIC_STEPS = 32;
  localparam int ZERO_LIMIT_W = 24;
  localparam int TOL_W = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_NORM_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_TOLERANCE = 2'd1;

  localparam logic [QW-1:0] Q_ONE = 33'h0_4000_0000;
  localparam logic [QW-1:0] Q_SAT = 33'h1_0000_0000;
  localparam logic [60:0] V_ONE = 61'h1000_0000_0000_0000;
  localparam logic [ZW-1:0] PI_HALF_Q40 = 44'd1727108826179;
  localparam logic [AW-1:0] PI_ANGLE = 18'd205887;
  localparam logic [ZW-1:0] ANGLE_HALF = 44'd8388608;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ZERO = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [NW-1:0] na;
    logic [NW-1:0] nb;
    logic          zero;
    logic          sgn;
  } norm_side_t;

  typedef struct packed {
    logic [NW-1:0] na;
    logic [NW-1:0] nb;
    status_t       status;
    logic          cordic;
    logic          is_pi;
  } ac_side_t;

  // Arc tangent of 2^-i in Q40 radians.
  function automatic logic [ZW-1:0] atan_q40(input int i);
    logic [ZW-1:0] res;
    case (i)
      0:  res = 44'd863554413089;
      1:  res = 44'd509785937287;
      2:  res = 44'd269356888665;
      3:  res = 44'd136729762476;
      4:  res = 44'd68630207382;
      5:  res = 44'd34348559968;
      6:  res = 44'd17178471285;
      7:  res = 44'd8589759836;
      8:  res = 44'd4294945451;
      9:  res = 44'd2147480917;
      10: res = 44'd1073741483;
      11: res = 44'd536870869;
      12: res = 44'd268435451;
      13: res = 44'd134217727;
      default: res = ZW'(64'd1 << (40 - i));
    endcase
    return res;
  endfunction

endpackage

### design/v3a_dot.sv
module v3a_dot import v3a_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [6*CW-1:0] comp,
  output logic            out_valid,
  output logic [SW-1:0]   sa,
  output logic [SW-1:0]   sb,
  output logic [SW-1:0]   num,
  output logic            sgn
);

  logic [CW-1:0] ma [3];
  logic [CW-1:0] mb [3];
  logic          xneg [3];
  logic [SW-1:0] pa [3];
  logic [SW-1:0] pb [3];
  logic [SW-1:0] pc [3];
  logic          xneg1 [3];
  logic [SW-1:0] sa2;
  logic [SW-1:0] sb2;
  logic [SW-1:0] pos2;
  logic [SW-1:0] neg2;
  logic [3:0]    vd;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma[i] <= comp[i*CW+CW-1] ? (~comp[i*CW +: CW] + CW'(1)) : comp[i*CW +: CW];
        mb[i] <= comp[(i+3)*CW+CW-1] ? (~comp[(i+3)*CW +: CW] + CW'(1))
                                     : comp[(i+3)*CW +: CW];
        xneg[i] <= comp[i*CW+CW-1] ^ comp[(i+3)*CW+CW-1];
        pa[i] <= ma[i] * ma[i];
        pb[i] <= mb[i] * mb[i];
        pc[i] <= ma[i] * mb[i];
        xneg1[i] <= xneg[i];
      end
      sa2 <= pa[0] + pa[1] + pa[2];
      sb2 <= pb[0] + pb[1] + pb[2];
      pos2 <= (xneg1[0] ? '0 : pc[0]) + (xneg1[1] ? '0 : pc[1]) + (xneg1[2] ? '0 : pc[2]);
      neg2 <= (xneg1[0] ? pc[0] : '0) + (xneg1[1] ? pc[1] : '0) + (xneg1[2] ? pc[2] : '0);
      sa <= sa2;
      sb <= sb2;
      num <= (pos2 >= neg2) ? pos2 - neg2 : neg2 - pos2;
      sgn <= pos2 < neg2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[2:0], in_valid};
    end
  end

  assign out_valid = vd[3];

endmodule

### design/v3a_norm.sv
module v3a_norm import v3a_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [SW-1:0]           sa,
  input  logic [SW-1:0]           sb,
  input  logic [SW-1:0]           num,
  input  logic                    sgn,
  input  logic [ZERO_LIMIT_W-1:0] lim,
  output logic                    out_valid,
  output logic [SW-1:0]           num_out,
  output logic [SW-1:0]           den,
  output norm_side_t              side
);

  logic [SW-1:0] sha [0:NORM_STEPS];
  logic [SW-1:0] shb [0:NORM_STEPS];
  logic [NW-1:0] rta [0:NORM_STEPS];
  logic [NW-1:0] rtb [0:NORM_STEPS];
  logic [NW+2:0] rma [0:NORM_STEPS];
  logic [NW+2:0] rmb [0:NORM_STEPS];
  logic [SW-1:0] numd [0:NORM_STEPS];
  logic          sgnd [0:NORM_STEPS];
  logic          vd [0:NORM_STEPS];
  logic [NW-1:0] na_r;
  logic [NW-1:0] nb_r;
  logic [SW-1:0] num_r;
  logic          sgn_r;
  logic          v_r;

  assign sha[0] = sa;
  assign shb[0] = sb;
  assign rta[0] = '0;
  assign rtb[0] = '0;
  assign rma[0] = '0;
  assign rmb[0] = '0;
  assign numd[0] = num;
  assign sgnd[0] = sgn;
  assign vd[0] = in_valid;

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_root
    logic [NW+2:0] cura;
    logic [NW+2:0] tra;
    logic [NW+2:0] curb;
    logic [NW+2:0] trb;

    assign cura = {rma[j][NW:0], sha[j][SW-1 -: 2]};
    assign tra = {1'b0, rta[j], 2'b01};
    assign curb = {rmb[j][NW:0], shb[j][SW-1 -: 2]};
    assign trb = {1'b0, rtb[j], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        sha[j+1] <= {sha[j][SW-3:0], 2'b00};
        shb[j+1] <= {shb[j][SW-3:0], 2'b00};
        numd[j+1] <= numd[j];
        sgnd[j+1] <= sgnd[j];
        if (cura >= tra) begin
          rma[j+1] <= cura - tra;
          rta[j+1] <= {rta[j][NW-2:0], 1'b1};
        end else begin
          rma[j+1] <= cura;
          rta[j+1] <= {rta[j][NW-2:0], 1'b0};
        end
        if (curb >= trb) begin
          rmb[j+1] <= curb - trb;
          rtb[j+1] <= {rtb[j][NW-2:0], 1'b1};
        end else begin
          rmb[j+1] <= curb;
          rtb[j+1] <= {rtb[j][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (en) begin
        vd[j+1] <= vd[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r <= rta[NORM_STEPS] + NW'(rma[NORM_STEPS] > {3'b000, rta[NORM_STEPS]});
      nb_r <= rtb[NORM_STEPS] + NW'(rmb[NORM_STEPS] > {3'b000, rtb[NORM_STEPS]});
      num_r <= numd[NORM_STEPS];
      sgn_r <= sgnd[NORM_STEPS];
      den <= na_r * nb_r;
      num_out <= num_r;
      side.na <= na_r;
      side.nb <= nb_r;
      side.sgn <= sgn_r;
      side.zero <= (na_r == '0) || (nb_r == '0) || (na_r < lim) || (nb_r < lim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_r <= vd[NORM_STEPS];
      out_valid <= v_r;
    end
  end

endmodule

### design/v3a_div.sv
module v3a_div import v3a_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [SW-1:0] num,
  input  logic [SW-1:0] den,
  input  norm_side_t    side_in,
  output logic          out_valid,
  output logic [QW-1:0] q,
  output norm_side_t    side_out
);

  logic [SW-1:0] rr [0:DIV_STEPS];
  logic [QW-1:0] qq [0:DIV_STEPS];
  logic [SW-1:0] dd [0:DIV_STEPS];
  logic          sat [0:DIV_STEPS];
  norm_side_t    sd [0:DIV_STEPS];
  logic          vd [0:DIV_STEPS];
  logic          ge2;
  logic [QW:0]   qsum;

  assign ge2 = {1'b0, num} >= {den, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= {2'b00, num} >= {den, 2'b00};
      rr[0] <= ge2 ? num - {den[SW-2:0], 1'b0} : num;
      qq[0] <= QW'(ge2);
      dd[0] <= den;
      sd[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= in_valid;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [SW:0] t;
    logic        take;

    if (j == 0) begin : g_int
      assign t = {1'b0, rr[j]};
    end else begin : g_frac
      assign t = {rr[j], 1'b0};
    end
    assign take = t >= {1'b0, dd[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        rr[j+1] <= take ? SW'(t - {1'b0, dd[j]}) : t[SW-1:0];
        qq[j+1] <= {qq[j][QW-2:0], take};
        dd[j+1] <= dd[j];
        sat[j+1] <= sat[j];
        sd[j+1] <= sd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (en) begin
        vd[j+1] <= vd[j];
      end
    end
  end

  assign qsum = {1'b0, qq[DIV_STEPS]} + (QW+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= sat[DIV_STEPS] ? Q_SAT : qsum[QW:1];
      side_out <= sd[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[DIV_STEPS];
    end
  end

endmodule

### design/v3a_acos.sv
module v3a_acos import v3a_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [QW-1:0]    q,
  input  norm_side_t       side_in,
  input  logic [TOL_W-1:0] tol,
  output logic             out_valid,
  output logic [AW-1:0]    angle,
  output logic [NW-1:0]    norm_a,
  output logic [NW-1:0]    norm_b,
  output status_t          status
);

  logic                   ge1;
  logic [QW-1:0]          over;
  logic                   tol_hit;
  ac_side_t               side0;
  logic [29:0]            qm0;
  logic                   cneg0;
  logic                   v0;
  ac_side_t               side1;
  logic [29:0]            qm1;
  logic                   cneg1;
  logic [59:0]            c2;
  logic                   v1;
  logic [61:0]            sh [0:ROOT_STEPS];
  logic [RW-1:0]          rt [0:ROOT_STEPS];
  logic [RW+2:0]          rm [0:ROOT_STEPS];
  logic [29:0]            qmd [0:ROOT_STEPS];
  logic                   cnd [0:ROOT_STEPS];
  ac_side_t               sdr [0:ROOT_STEPS];
  logic                   vdr [0:ROOT_STEPS];
  logic [RW-1:0]          s_r;
  logic [29:0]            qm_r;
  logic                   cneg_r;
  ac_side_t               side_r;
  logic                   v_r;
  logic signed [XW-1:0]   xs [0:CORDIC_STEPS];
  logic signed [XW-1:0]   ys [0:CORDIC_STEPS];
  logic [ZW-1:0]          zs [0:CORDIC_STEPS];
  ac_side_t               sdc [0:CORDIC_STEPS];
  logic                   vdc [0:CORDIC_STEPS];
  logic [ZW-1:0]          zr;
  logic [AW-1:0]          ang_c;

  assign ge1 = q >= Q_ONE;
  assign over = q - Q_ONE;
  assign tol_hit = over < {12'd0, tol};

  always_ff @(posedge clk) begin
    if (en) begin
      side0.na <= side_in.na;
      side0.nb <= side_in.nb;
      if (side_in.zero) begin
        side0.status <= ST_ZERO;
      end else if (ge1 && !side_in.sgn && !tol_hit) begin
        side0.status <= ST_RANGE;
      end else begin
        side0.status <= ST_OK;
      end
      side0.cordic <= !side_in.zero && !ge1;
      side0.is_pi <= !side_in.zero && ge1 && side_in.sgn;
      qm0 <= q[29:0];
      cneg0 <= side_in.sgn && (q != '0);
      side1 <= side0;
      qm1 <= qm0;
      cneg1 <= cneg0;
      c2 <= qm0 * qm0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh[0] <= {1'b0, V_ONE - {1'b0, c2}};
      qmd[0] <= qm1;
      cnd[0] <= cneg1;
      sdr[0] <= side1;
    end
  end

  assign rt[0] = '0;
  assign rm[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      vdr[0] <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      vdr[0] <= v1;
    end
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    logic [RW+2:0] cur;
    logic [RW+2:0] tr;

    assign cur = {rm[j][RW:0], sh[j][61:60]};
    assign tr = {1'b0, rt[j], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        sh[j+1] <= {sh[j][59:0], 2'b00};
        qmd[j+1] <= qmd[j];
        cnd[j+1] <= cnd[j];
        sdr[j+1] <= sdr[j];
        if (cur >= tr) begin
          rm[j+1] <= cur - tr;
          rt[j+1] <= {rt[j][RW-2:0], 1'b1};
        end else begin
          rm[j+1] <= cur;
          rt[j+1] <= {rt[j][RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vdr[j+1] <= 1'b0;
      end else if (en) begin
        vdr[j+1] <= vdr[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= rt[ROOT_STEPS] + RW'(rm[ROOT_STEPS] > {3'b000, rt[ROOT_STEPS]});
      qm_r <= qmd[ROOT_STEPS];
      cneg_r <= cnd[ROOT_STEPS];
      side_r <= sdr[ROOT_STEPS];
      xs[0] <= cneg_r ? {3'b000, s_r} : {4'b0000, qm_r};
      ys[0] <= cneg_r ? {4'b0000, qm_r} : {3'b000, s_r};
      zs[0] <= cneg_r ? PI_HALF_Q40 : '0;
      sdc[0] <= side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
      vdc[0] <= 1'b0;
    end else if (en) begin
      v_r <= vdr[ROOT_STEPS];
      vdc[0] <= v_r;
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    localparam logic [ZW-1:0] AT = atan_q40(j);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = ys[j] >>> j;
    assign dy = xs[j] >>> j;

    always_ff @(posedge clk) begin
      if (en) begin
        sdc[j+1] <= sdc[j];
        if (!ys[j][XW-1]) begin
          xs[j+1] <= xs[j] + dx;
          ys[j+1] <= ys[j] - dy;
          zs[j+1] <= zs[j] + AT;
        end else begin
          xs[j+1] <= xs[j] - dx;
          ys[j+1] <= ys[j] + dy;
          zs[j+1] <= zs[j] - AT;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vdc[j+1] <= 1'b0;
      end else if (en) begin
        vdc[j+1] <= vdc[j];
      end
    end
  end

  assign zr = zs[CORDIC_STEPS] + ANGLE_HALF;
  assign ang_c = zs[CORDIC_STEPS][ZW-1] ? '0 : zr[24 +: AW];

  always_comb begin
    if (sdc[CORDIC_STEPS].cordic) begin
      angle = ang_c;
    end else if (sdc[CORDIC_STEPS].is_pi) begin
      angle = PI_ANGLE;
    end else begin
      angle = '0;
    end
  end

  assign norm_a = sdc[CORDIC_STEPS].na;
  assign norm_b = sdc[CORDIC_STEPS].nb;
  assign status = sdc[CORDIC_STEPS].status;
  assign out_valid = vdc[CORDIC_STEPS];

endmodule

### design/vector3_angle_unit_core.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or its word is being taken.
// Reset: rst clears all valid bits and the output valid flag, and sets
// zero_norm_limit and cos_tolerance to 1.
module vector3_angle_unit_core import v3a_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [6*CW-1:0]       s_tdata,   // ax, ay, az, bx, by, bz
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,   // angle, norm_a, norm_b, zero pad
  output logic [1:0]            m_tuser,   // status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                    en;
  logic [ZERO_LIMIT_W-1:0] zero_norm_limit;
  logic [TOL_W-1:0]        cos_tolerance;
  logic                    dot_valid;
  logic [SW-1:0]           sa;
  logic [SW-1:0]           sb;
  logic [SW-1:0]           num;
  logic                    sgn;
  logic                    norm_valid;
  logic [SW-1:0]           norm_num;
  logic [SW-1:0]           den;
  norm_side_t              norm_side;
  logic                    div_valid;
  logic [QW-1:0]           q;
  norm_side_t              div_side;
  logic                    ac_valid;
  logic [AW-1:0]           angle;
  logic [NW-1:0]           norm_a;
  logic [NW-1:0]           norm_b;
  status_t                 status;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_norm_limit <= ZERO_LIMIT_W'(1);
      cos_tolerance <= TOL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_NORM_LIMIT: zero_norm_limit <= cfg_data[ZERO_LIMIT_W-1:0];
        REG_COS_TOLERANCE:   cos_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  v3a_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .comp      (s_tdata),
    .out_valid (dot_valid),
    .sa        (sa),
    .sb        (sb),
    .num       (num),
    .sgn       (sgn)
  );

  v3a_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dot_valid),
    .sa        (sa),
    .sb        (sb),
    .num       (num),
    .sgn       (sgn),
    .lim       (zero_norm_limit),
    .out_valid (norm_valid),
    .num_out   (norm_num),
    .den       (den),
    .side      (norm_side)
  );

  v3a_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .num       (norm_num),
    .den       (den),
    .side_in   (norm_side),
    .out_valid (div_valid),
    .q         (q),
    .side_out  (div_side)
  );

  v3a_acos u_acos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .q         (q),
    .side_in   (div_side),
    .tol       (cos_tolerance),
    .out_valid (ac_valid),
    .angle     (angle),
    .norm_a    (norm_a),
    .norm_b    (norm_b),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'd0, norm_b, norm_a, angle};
      m_tuser <= status;
    end
  end

endmodule
